@@ sv/rwmm_pkg.sv @@
`default_nettype none

package rwmm_pkg;

    // Field widths of the result item and the input sample, fixed by the interface.
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int COUNT_W = 4;

    // Operation codes.
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIVGO,
        ST_DIV
    } state_t;

endpackage

`default_nettype wire

@@ sv/rwmm_store.sv @@
`default_nettype none

module rwmm_store #(
    parameter int DEPTH = 10,
    parameter int WIDTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/rwmm_div.sv @@
`default_nettype none

module rwmm_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic        [DEN_W-1:0] divisor,
    output logic signed      [NUM_W-1:0] quotient,
    output logic                         done
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  q_out_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = !diff[DEN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                if (step_reg != '0)
                begin
                    step_reg <= step_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            neg_reg <= dividend[NUM_W-1];
            quo_reg <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (step_reg != '0)
            begin
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            end
            else
            begin
                // The magnitude quotient takes the dividend's sign: truncation toward zero.
                q_out_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
        end
    end

    assign quotient = q_out_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

@@ sv/ring_window_min_max_mean_unit.sv @@
// Store item: busy stays low and the next item may follow at once.
// Report item over n stored samples: one store read per entry, then one divider step per
// bit of the sum, whose width is W = SAMPLE_WIDTH + clog2(DEPTH + 1); busy is high
// throughout until the strobe done rises. A report on an empty window answers zeros
// in the next cycle.
// Reset clears the write pointer, the fill count and control; stored samples are not cleared.
`default_nettype none

module ring_window_min_max_mean_unit
    import rwmm_pkg::*;
#(
    parameter int DEPTH        = 10,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     op,
    input  wire logic signed [IN_W-1:0]   sample_value,
    output logic                          done,
    output logic signed      [OUT_W-1:0]  mean_value,
    output logic signed      [OUT_W-1:0]  min_value,
    output logic signed      [OUT_W-1:0]  max_value,
    output logic             [COUNT_W-1:0] sample_count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(2 * DEPTH + 1);
    localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] wp_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] left_reg;
    logic             first_reg;
    logic             rd_vld_reg;

    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;

    logic                    done_reg;
    logic signed [OUT_W-1:0] mean_reg;
    logic signed [OUT_W-1:0] min_out_reg;
    logic signed [OUT_W-1:0] max_out_reg;
    logic [COUNT_W-1:0]      cnt_out_reg;

    logic accept;
    logic wr_en;
    logic begin_walk;
    logic empty_rep;
    logic rd_en;
    logic last;
    logic div_start;

    logic signed [SAMPLE_WIDTH-1:0] rd_data;
    logic signed [SAMPLE_WIDTH-1:0] wr_data;
    logic signed [SUM_W-1:0]        quotient;
    logic                           div_done;

    logic [PTR_W-1:0] oldest_raw;
    logic [IDX_W-1:0] oldest_idx;

    assign busy    = (state_reg != ST_IDLE);
    assign wr_data = SAMPLE_WIDTH'(sample_value);

    // Oldest filled entry: (pointer - count) mod DEPTH, with count never above DEPTH.
    always_comb
    begin
        oldest_raw = PTR_W'(wp_reg) + PTR_DEPTH - PTR_W'(fill_reg);
        if (oldest_raw >= PTR_DEPTH)
        begin
            oldest_raw = oldest_raw - PTR_DEPTH;
        end
        oldest_idx = oldest_raw[IDX_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (begin_walk)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last)
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        accept     = start && !busy;
        wr_en      = accept && (op == OP_STORE);
        begin_walk = accept && (op == OP_REPORT) && (fill_reg != '0);
        empty_rep  = accept && (op == OP_REPORT) && (fill_reg == '0);
        rd_en      = (state_reg == ST_WALK) && (left_reg != '0);
        last       = (state_reg == ST_WALK) && rd_vld_reg && (left_reg == '0);
        div_start  = (state_reg == ST_DIVGO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            left_reg   <= '0;
            rd_vld_reg <= 1'b0;
            first_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            done_reg   <= empty_rep || ((state_reg == ST_DIV) && div_done);
            if (wr_en)
            begin
                wp_reg <= (wp_reg == IDX_LAST) ? '0 : wp_reg + 1'b1;
                if (fill_reg != CNT_FULL)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (begin_walk)
            begin
                left_reg  <= fill_reg;
                first_reg <= 1'b1;
            end
            else
            begin
                if (rd_en)
                begin
                    left_reg <= left_reg - 1'b1;
                end
                if (rd_vld_reg)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (begin_walk)
        begin
            rd_idx_reg <= oldest_idx;
        end
        else if (rd_en)
        begin
            rd_idx_reg <= (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
        end

        if (rd_vld_reg)
        begin
            if (first_reg)
            begin
                sum_reg <= SUM_W'(rd_data);
                min_reg <= rd_data;
                max_reg <= rd_data;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(rd_data);
                if (rd_data < min_reg)
                begin
                    min_reg <= rd_data;
                end
                if (rd_data > max_reg)
                begin
                    max_reg <= rd_data;
                end
            end
        end

        if (empty_rep)
        begin
            mean_reg    <= '0;
            min_out_reg <= '0;
            max_out_reg <= '0;
            cnt_out_reg <= '0;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            mean_reg    <= OUT_W'(quotient);
            min_out_reg <= OUT_W'(min_reg);
            max_out_reg <= OUT_W'(max_reg);
            cnt_out_reg <= COUNT_W'(fill_reg);
        end
    end

    rwmm_store #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_WIDTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    rwmm_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign done         = done_reg;
    assign mean_value   = mean_reg;
    assign min_value    = min_out_reg;
    assign max_value    = max_out_reg;
    assign sample_count = cnt_out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("fill count above window depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= IDX_LAST)
        else $error("write pointer out of range");

    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        begin_walk |=> busy)
        else $error("report on a filled window did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (min_value <= max_value))
        else $error("reported minimum above maximum");

endmodule

`default_nettype wire
